// ----- design/scc_pkg.sv -----
// Shared types and constants for the strongly connected components block.
package scc_pkg;

  localparam int unsigned NODE_W    = 6;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned QDEPTH    = 4;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

endpackage

// ----- design/scc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module scc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/scc_front.sv -----
// Front end: node count register, input acceptance and the item queue.
module scc_front #(
  parameter int unsigned NODES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  scc_pkg::item_t              item_i,
  output scc_pkg::queue_t             q_o,
  input  logic                        q_pop_i,
  output logic [$clog2(NODES+1)-1:0]  n_o
);

  localparam int unsigned NW  = $clog2(NODES + 1);
  localparam int unsigned QA  = $clog2(scc_pkg::QDEPTH);
  localparam int unsigned QC  = $clog2(scc_pkg::QDEPTH + 1);

  logic [scc_pkg::CFG_W-1:0] ncnt_q;
  scc_pkg::item_t            fifo_q [scc_pkg::QDEPTH];
  logic [QA-1:0]             wp_q, rp_q;
  logic [QC-1:0]             cnt_q;
  logic                      push, pop;

  assign in_stall_o = (cnt_q == QC'(scc_pkg::QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != '0);

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = fifo_q[rp_q];

  always_comb begin
    if (ncnt_q == '0) begin
      n_o = NW'(1);
    end else if (32'(ncnt_q) > NODES) begin
      n_o = NW'(NODES);
    end else begin
      n_o = NW'(ncnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q <= scc_pkg::NODE_COUNT_RST;
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        ncnt_q <= cfg_data_i;
      end
      if (push) begin
        wp_q <= wp_q + QA'(1);
      end
      if (pop) begin
        rp_q <= rp_q + QA'(1);
      end
      cnt_q <= cnt_q + QC'(push) - QC'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= item_i;
    end
  end

endmodule

// ----- design/scc_back.sv -----
// Back end: edge store, Tarjan search engine and result register.
module scc_back #(
  parameter int unsigned NODES = 64,
  parameter int unsigned EDGES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scc_pkg::queue_t                   q_i,
  output logic                              q_pop_o,
  input  logic [$clog2(NODES+1)-1:0]        n_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [scc_pkg::NODE_W-1:0]        member_node_o,
  output logic [scc_pkg::NODE_W-1:0]        component_number_o,
  output logic                              component_end_o,
  output logic                              last_o,
  output logic                              edges_dropped_o
);

  localparam int unsigned NA = $clog2(NODES);
  localparam int unsigned NW = $clog2(NODES + 1);
  localparam int unsigned AW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int unsigned CW = $clog2(EDGES + 1);
  localparam int unsigned FW = NA + AW + AW + 1 + NA + NA;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROOT = 4'd1;
  localparam logic [3:0] S_V1   = 4'd2;
  localparam logic [3:0] S_STEP = 4'd3;
  localparam logic [3:0] S_A1   = 4'd4;
  localparam logic [3:0] S_A2   = 4'd5;
  localparam logic [3:0] S_P0   = 4'd6;
  localparam logic [3:0] S_P1   = 4'd7;
  localparam logic [3:0] S_RET  = 4'd8;
  localparam logic [3:0] S_R1   = 4'd9;

  logic [3:0]       st_q, st_d;
  logic [NW-1:0]    root_q, root_d;
  logic [NA-1:0]    vn_q, vn_d;
  logic [NA-1:0]    tv_q, tv_d;
  logic [AW-1:0]    te_q, te_d;
  logic [AW-1:0]    ttail_q, ttail_d;
  logic             tmore_q, tmore_d;
  logic [NA-1:0]    tlow_q, tlow_d;
  logic [NA-1:0]    tord_q, tord_d;
  logic             top_q, top_d;
  logic [NW-1:0]    cd_q, cd_d;
  logic [NW-1:0]    fd_q, fd_d;
  logic [NA-1:0]    ord_q, ord_d;
  logic [NA-1:0]    comp_q, comp_d;
  logic [NW-1:0]    emit_q, emit_d;
  logic [NODES-1:0] vis_q, vis_d;
  logic [NODES-1:0] onstk_q, onstk_d;
  logic [NODES-1:0] lval_q, lval_d;
  logic [CW-1:0]    ecnt_q, ecnt_d;
  logic             drop_q, drop_d;

  logic                      s1_v_q, s1_v_d;
  logic [scc_pkg::NODE_W-1:0] s1_s_q, s1_t_q;
  logic                      lw_v_q, lw_v_d;
  logic [NA-1:0]             lw_s_q;
  logic [AW-1:0]             lw_cnt_q;

  logic                      ov_q, ov_d;
  logic [scc_pkg::NODE_W-1:0] om_q, oc_q;
  logic                      oe_q, ol_q, odr_q;
  logic                      oload;

  logic             do_visit;
  logic [NA-1:0]    vis_node;

  logic             ht_re;
  logic [NA-1:0]    ht_raddr;
  logic [AW-1:0]    head_rd, tail_rd;
  logic             head_we, tail_we;
  logic [NA-1:0]    ht_waddr;
  logic [AW-1:0]    ht_wdata;

  logic             tgt_we, lnk_we, edge_re;
  logic [AW-1:0]    lnk_waddr;
  logic [NA-1:0]    tgt_rd;
  logic [AW-1:0]    lnk_rd;

  logic             ordm_re;
  logic [NA-1:0]    ordm_rd;

  logic             cs_re;
  logic [NA-1:0]    cs_rd;

  logic             fr_we, fr_re;
  logic [FW-1:0]    fr_wdata, fr_rd;

  logic             s1_ok;
  logic [NA-1:0]    s1_sa;
  logic [AW-1:0]    s1_tail;
  logic [AW-1:0]    s1_cnt;

  logic             w_ok;
  logic [NA-1:0]    f_v, f_low, f_ord;
  logic [AW-1:0]    f_e, f_tail;
  logic             f_more;

  assign s1_sa   = s1_s_q[NA-1:0];
  assign s1_cnt  = ecnt_q[AW-1:0];
  assign s1_ok   = s1_v_q && ({1'b0, s1_s_q} < (scc_pkg::NODE_W+1)'(n_i))
                   && ({1'b0, s1_t_q} < (scc_pkg::NODE_W+1)'(n_i))
                   && (ecnt_q < CW'(EDGES));
  assign s1_tail = (lw_v_q && (lw_s_q == s1_sa)) ? lw_cnt_q : tail_rd;

  assign head_we   = s1_ok && !lval_q[s1_sa];
  assign tail_we   = s1_ok;
  assign ht_waddr  = s1_sa;
  assign ht_wdata  = s1_cnt;
  assign tgt_we    = s1_ok;
  assign lnk_we    = s1_ok && lval_q[s1_sa];
  assign lnk_waddr = s1_tail;

  assign w_ok = ({1'b0, tgt_rd} < NW'(n_i));
  assign {f_v, f_e, f_tail, f_more, f_low, f_ord} = fr_rd;
  assign fr_wdata = {tv_q, te_d, ttail_q, tmore_d, tlow_q, tord_q};
  assign oload = (st_q == S_P1) && (!ov_q || !out_stall_i);

  always_comb begin
    st_d     = st_q;
    root_d   = root_q;
    vn_d     = vn_q;
    tv_d     = tv_q;
    te_d     = te_q;
    ttail_d  = ttail_q;
    tmore_d  = tmore_q;
    tlow_d   = tlow_q;
    tord_d   = tord_q;
    top_d    = top_q;
    cd_d     = cd_q;
    fd_d     = fd_q;
    ord_d    = ord_q;
    comp_d   = comp_q;
    emit_d   = emit_q;
    vis_d    = vis_q;
    onstk_d  = onstk_q;
    lval_d   = lval_q;
    ecnt_d   = ecnt_q;
    drop_d   = drop_q;
    s1_v_d   = 1'b0;
    lw_v_d   = s1_ok;
    ov_d     = ov_q && out_stall_i;
    q_pop_o  = 1'b0;
    do_visit = 1'b0;
    vis_node = root_q[NA-1:0];
    edge_re  = 1'b0;
    ordm_re  = 1'b0;
    cs_re    = 1'b0;
    fr_re    = 1'b0;
    fr_we    = 1'b0;
    ht_re    = 1'b1;

    if (s1_v_q) begin
      if (s1_ok) begin
        lval_d[s1_sa] = 1'b1;
        ecnt_d        = ecnt_q + CW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end

    unique case (st_q)
      S_IDLE: begin
        if (q_i.valid) begin
          q_pop_o = 1'b1;
          if (q_i.item.mode == scc_pkg::MODE_RUN) begin
            st_d   = S_ROOT;
            root_d = '0;
            ord_d  = '0;
            comp_d = '0;
            emit_d = '0;
            top_d  = 1'b0;
          end else begin
            s1_v_d = 1'b1;
          end
        end
      end
      S_ROOT: begin
        if (root_q == n_i) begin
          lval_d = '0;
          ecnt_d = '0;
          drop_d = 1'b0;
          vis_d  = '0;
          st_d   = S_IDLE;
        end else if (!vis_q[root_q[NA-1:0]]) begin
          do_visit = 1'b1;
        end else begin
          root_d = root_q + NW'(1);
        end
      end
      S_V1: begin
        tv_d    = vn_q;
        te_d    = head_rd;
        ttail_d = tail_rd;
        tmore_d = lval_q[vn_q];
        tlow_d  = ord_q - NA'(1);
        tord_d  = ord_q - NA'(1);
        st_d    = S_STEP;
      end
      S_STEP: begin
        if (tmore_q) begin
          edge_re = 1'b1;
          st_d    = S_A1;
        end else if (tlow_q == tord_q) begin
          st_d = S_P0;
        end else begin
          st_d = S_RET;
        end
      end
      S_A1: begin
        tmore_d  = (te_q != ttail_q);
        te_d     = lnk_rd;
        vis_node = tgt_rd;
        ordm_re  = 1'b1;
        if (w_ok && !vis_q[tgt_rd]) begin
          do_visit = 1'b1;
        end else if (w_ok && onstk_q[tgt_rd]) begin
          st_d = S_A2;
        end else begin
          st_d = S_STEP;
        end
      end
      S_A2: begin
        if (ordm_rd < tlow_q) begin
          tlow_d = ordm_rd;
        end
        st_d = S_STEP;
      end
      S_P0: begin
        cs_re = 1'b1;
        cd_d  = cd_q - NW'(1);
        st_d  = S_P1;
      end
      S_P1: begin
        if (oload) begin
          ov_d          = 1'b1;
          onstk_d[cs_rd] = 1'b0;
          emit_d        = emit_q + NW'(1);
          if (cs_rd == tv_q) begin
            comp_d = comp_q + NA'(1);
            st_d   = S_RET;
          end else begin
            st_d = S_P0;
          end
        end
      end
      S_RET: begin
        if (fd_q != '0) begin
          fr_re = 1'b1;
          fd_d  = fd_q - NW'(1);
          st_d  = S_R1;
        end else begin
          top_d = 1'b0;
          st_d  = S_ROOT;
        end
      end
      S_R1: begin
        tv_d    = f_v;
        te_d    = f_e;
        ttail_d = f_tail;
        tmore_d = f_more;
        tord_d  = f_ord;
        tlow_d  = (tlow_q < f_low) ? tlow_q : f_low;
        st_d    = S_STEP;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    ht_raddr = (st_q == S_IDLE) ? q_i.item.source_node[NA-1:0] : vis_node;

    if (do_visit) begin
      vis_d[vis_node]   = 1'b1;
      onstk_d[vis_node] = 1'b1;
      cd_d              = cd_q + NW'(1);
      ord_d             = ord_q + NA'(1);
      vn_d              = vis_node;
      if (top_q) begin
        fr_we = 1'b1;
        fd_d  = fd_q + NW'(1);
      end
      top_d = 1'b1;
      st_d  = S_V1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      root_q  <= '0;
      top_q   <= 1'b0;
      cd_q    <= '0;
      fd_q    <= '0;
      ord_q   <= '0;
      comp_q  <= '0;
      emit_q  <= '0;
      vis_q   <= '0;
      onstk_q <= '0;
      lval_q  <= '0;
      ecnt_q  <= '0;
      drop_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      lw_v_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      root_q  <= root_d;
      top_q   <= top_d;
      cd_q    <= cd_d;
      fd_q    <= fd_d;
      ord_q   <= ord_d;
      comp_q  <= comp_d;
      emit_q  <= emit_d;
      vis_q   <= vis_d;
      onstk_q <= onstk_d;
      lval_q  <= lval_d;
      ecnt_q  <= ecnt_d;
      drop_q  <= drop_d;
      s1_v_q  <= s1_v_d;
      lw_v_q  <= lw_v_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vn_q     <= vn_d;
    tv_q     <= tv_d;
    te_q     <= te_d;
    ttail_q  <= ttail_d;
    tmore_q  <= tmore_d;
    tlow_q   <= tlow_d;
    tord_q   <= tord_d;
    s1_s_q   <= q_i.item.source_node;
    s1_t_q   <= q_i.item.target_node;
    lw_s_q   <= s1_sa;
    lw_cnt_q <= s1_cnt;
    if (oload) begin
      om_q  <= scc_pkg::NODE_W'(cs_rd);
      oc_q  <= scc_pkg::NODE_W'(comp_q);
      oe_q  <= (cs_rd == tv_q);
      ol_q  <= (emit_q == n_i - NW'(1));
      odr_q <= drop_q;
    end
  end

  scc_ram #(.WIDTH(AW), .DEPTH(NODES)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(ht_waddr), .wdata_i(ht_wdata),
    .re_i(ht_re), .raddr_i(ht_raddr), .rdata_o(head_rd)
  );

  scc_ram #(.WIDTH(AW), .DEPTH(NODES)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(ht_waddr), .wdata_i(ht_wdata),
    .re_i(ht_re), .raddr_i(ht_raddr), .rdata_o(tail_rd)
  );

  scc_ram #(.WIDTH(NA), .DEPTH(EDGES)) u_target (
    .clk_i, .we_i(tgt_we), .waddr_i(s1_cnt), .wdata_i(s1_t_q[NA-1:0]),
    .re_i(edge_re), .raddr_i(te_q), .rdata_o(tgt_rd)
  );

  scc_ram #(.WIDTH(AW), .DEPTH(EDGES)) u_link (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_waddr), .wdata_i(s1_cnt),
    .re_i(edge_re), .raddr_i(te_q), .rdata_o(lnk_rd)
  );

  scc_ram #(.WIDTH(NA), .DEPTH(NODES)) u_order (
    .clk_i, .we_i(do_visit), .waddr_i(vis_node), .wdata_i(ord_q),
    .re_i(ordm_re), .raddr_i(tgt_rd), .rdata_o(ordm_rd)
  );

  scc_ram #(.WIDTH(NA), .DEPTH(NODES)) u_cstack (
    .clk_i, .we_i(do_visit), .waddr_i(cd_q[NA-1:0]), .wdata_i(vis_node),
    .re_i(cs_re), .raddr_i(cd_d[NA-1:0]), .rdata_o(cs_rd)
  );

  scc_ram #(.WIDTH(FW), .DEPTH(NODES)) u_frame (
    .clk_i, .we_i(fr_we), .waddr_i(fd_q[NA-1:0]), .wdata_i(fr_wdata),
    .re_i(fr_re), .raddr_i(fd_d[NA-1:0]), .rdata_o(fr_rd)
  );

  assign out_valid_o        = ov_q;
  assign member_node_o      = om_q;
  assign component_number_o = oc_q;
  assign component_end_o    = oe_q;
  assign last_o             = ol_q;
  assign edges_dropped_o    = odr_q;

`ifndef ASSERT_OFF
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cd_q <= NW'(NODES)) && (fd_q <= NW'(NODES)))
    else $error("stack depth overflow");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> ((cd_q == '0) && (fd_q == '0) && (onstk_q == '0)))
    else $error("stacks not empty when idle");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oload |-> (emit_q < n_i))
    else $error("more results than nodes");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (st_q == S_IDLE))
    else $error("queue popped while searching");
`endif

endmodule

// ----- design/strongly_connected_components_top.sv -----
// Top level of the strongly connected components block.
// Edge words: accepted one per cycle while the queue has room; written via the s1 register.
// Run word: checks each root, visits nodes, follows edges with one more step when an edge
// meets a node on the stack, emits members and returns frames; output stalls hold it.
// Results leave through a one-deep output register; a 4-deep queue parts input from search.
// Reset clears all lists, the drop flag and node_count to 64; no memory clearing pass.
module strongly_connected_components_top #(
  parameter int unsigned NODES = 64,
  parameter int unsigned EDGES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [scc_pkg::NODE_W-1:0]  source_node_i,
  input  logic [scc_pkg::NODE_W-1:0]  target_node_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [scc_pkg::NODE_W-1:0]  member_node_o,
  output logic [scc_pkg::NODE_W-1:0]  component_number_o,
  output logic                        component_end_o,
  output logic                        last_o,
  output logic                        edges_dropped_o
);

  scc_pkg::item_t               item;
  scc_pkg::queue_t              q;
  logic                         q_pop;
  logic [$clog2(NODES+1)-1:0]   n;

  assign item.mode        = mode_i;
  assign item.source_node = source_node_i;
  assign item.target_node = target_node_i;

  scc_front #(.NODES(NODES)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .item_i(item), .q_o(q), .q_pop_i(q_pop), .n_o(n)
  );

  scc_back #(.NODES(NODES), .EDGES(EDGES)) u_back (
    .clk_i, .rst_ni, .q_i(q), .q_pop_o(q_pop), .n_i(n),
    .out_valid_o, .out_stall_i, .member_node_o, .component_number_o,
    .component_end_o, .last_o, .edges_dropped_o
  );

endmodule
